/* hdl/bcot_pkg.sv */
// shared types, codes and helpers for the box corner overlap test unit
package bcot_pkg;

	localparam int NUM_BOXES = 2;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CORNER_DEPTH = NUM_BOXES * 24;
	localparam int CORNER_AW = $clog2(CORNER_DEPTH);

	// operation codes
	localparam logic [1:0] OP_SET_BOX = 2'd0;
	localparam logic [1:0] OP_LOAD_ROW = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;
	localparam logic [1:0] OP_TEST = 2'd3;

	// destination of a finished product
	localparam logic [2:0] DST_NONE = 3'd0;
	localparam logic [2:0] DST_FIRST = 3'd1;
	localparam logic [2:0] DST_MID = 3'd2;
	localparam logic [2:0] DST_LAST = 3'd3;
	localparam logic [2:0] DST_EDGE = 3'd4;

	// datapath command, one per cycle
	typedef struct packed {
		logic mul_en;
		logic mul_edge;
		logic [1:0] col;
		logic [2:0] dst;
		logic wr_en;
		logic [2:0] corner;
		logic rd_en;
		logic rd_other;
		logic rd_first;
		logic cmp_en;
		logic cmp_first;
		logic [1:0] axis;
	} cmd_t;

	// edges added for each corner, bit j = edge j
	function automatic logic [2:0] corner_sel(input logic [2:0] c);
		logic [2:0] s;
		unique case (c)
			3'd0: s = 3'b000;
			3'd1: s = 3'b001;
			3'd2: s = 3'b010;
			3'd3: s = 3'b100;
			3'd4: s = 3'b011;
			3'd5: s = 3'b101;
			3'd6: s = 3'b110;
			default: s = 3'b111;
		endcase
		return s;
	endfunction

	// saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
		logic signed [31:0] r;
		if (v > 67'sh0_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -67'sh0_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

/* hdl/bcot_dp.sv */
// datapath: box state, shared multiplier, corner memory and interval compare
module bcot_dp #(
	parameter int FRAC_BITS = bcot_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic load,
	input logic [1:0] op,
	input logic box,
	input logic [1:0] row,
	input logic [191:0] vals,
	input bcot_pkg::cmd_t cmd,
	output logic ovl
);

	logic signed [31:0] org_q [2][3];
	logic signed [31:0] ext_q [2][3];
	logic signed [31:0] mat_q [2][3][4];
	logic box_q;
	logic signed [31:0] v [6];

	logic signed [63:0] prod_s1;
	logic [2:0] dst_s1;
	logic [1:0] col_s1;
	logic signed [65:0] acc_q;
	logic signed [31:0] off_q;
	logic signed [31:0] ed_q [3];

	logic signed [31:0] corner_mem [bcot_pkg::CORNER_DEPTH];
	logic [bcot_pkg::CORNER_DEPTH-1:0] cvalid_q;
	logic signed [31:0] rdata_s1;
	logic rdv_s1;
	logic rdoth_s1;
	logic rdfirst_s1;
	logic signed [31:0] amin_q, amax_q, bmin_q, bmax_q;
	logic ovl_q;

	// input slices
	always_comb begin
		for (int k = 0; k < 6; k++)
			v[k] = $signed(vals[32*k +: 32]);
	end

	// box state writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < 2; b++)
				for (int a = 0; a < 3; a++) begin
					org_q[b][a] <= '0;
					ext_q[b][a] <= '0;
					for (int c = 0; c < 4; c++)
						mat_q[b][a][c] <= '0;
				end
			box_q <= 1'b0;
		end else if (load) begin
			box_q <= box;
			if (op == bcot_pkg::OP_SET_BOX) begin
				for (int a = 0; a < 3; a++) begin
					org_q[box][a] <= v[a];
					ext_q[box][a] <= v[a+3];
				end
			end else if (op == bcot_pkg::OP_LOAD_ROW && row != 2'd3) begin
				for (int c = 0; c < 4; c++)
					mat_q[box][row[1:0]][c] <= v[c];
			end
		end
	end

	// multiplier operands
	logic signed [31:0] mul_a, mul_b;
	always_comb begin
		mul_a = mat_q[box_q][cmd.axis][cmd.col];
		mul_b = cmd.mul_edge ? ext_q[box_q][cmd.col] : org_q[box_q][cmd.col];
	end

	// product register
	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_s1 <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_s1 <= bcot_pkg::DST_NONE;
			col_s1 <= '0;
		end else begin
			dst_s1 <= cmd.mul_en ? cmd.dst : bcot_pkg::DST_NONE;
			col_s1 <= cmd.col;
		end
	end

	// accumulate, round down, translate, saturate
	logic signed [65:0] acc_in, acc_sum, off_sh;
	logic signed [63:0] ed_sh;
	logic signed [31:0] trans;
	always_comb begin
		acc_in = (dst_s1 == bcot_pkg::DST_FIRST) ? 66'sd0 : acc_q;
		acc_sum = acc_in + {{2{prod_s1[63]}}, prod_s1};
		off_sh = acc_sum >>> FRAC_BITS;
		ed_sh = prod_s1 >>> FRAC_BITS;
		trans = mat_q[box_q][cmd.axis][3];
	end

	always_ff @(posedge clk) begin
		priority case (dst_s1)
			bcot_pkg::DST_FIRST, bcot_pkg::DST_MID: acc_q <= acc_sum;
			bcot_pkg::DST_LAST: off_q <= bcot_pkg::sat32({off_sh[65], off_sh}
				+ {{35{trans[31]}}, trans});
			bcot_pkg::DST_EDGE: ed_q[col_s1] <= bcot_pkg::sat32({{3{ed_sh[63]}}, ed_sh});
			default: ;
		endcase
	end

	// corner sum for the write command
	logic [2:0] sel;
	logic signed [33:0] csum;
	logic [bcot_pkg::CORNER_AW-1:0] waddr, raddr;
	logic rbox;
	always_comb begin
		sel = bcot_pkg::corner_sel(cmd.corner);
		csum = {{2{off_q[31]}}, off_q}
			+ (sel[0] ? {{2{ed_q[0][31]}}, ed_q[0]} : 34'sd0)
			+ (sel[1] ? {{2{ed_q[1][31]}}, ed_q[1]} : 34'sd0)
			+ (sel[2] ? {{2{ed_q[2][31]}}, ed_q[2]} : 34'sd0);
		rbox = cmd.rd_other ? ~box_q : box_q;
		waddr = bcot_pkg::CORNER_AW'(box_q) * bcot_pkg::CORNER_AW'(24)
			+ bcot_pkg::CORNER_AW'(cmd.corner) * bcot_pkg::CORNER_AW'(3)
			+ bcot_pkg::CORNER_AW'(cmd.axis);
		raddr = bcot_pkg::CORNER_AW'(rbox) * bcot_pkg::CORNER_AW'(24)
			+ bcot_pkg::CORNER_AW'(cmd.corner) * bcot_pkg::CORNER_AW'(3)
			+ bcot_pkg::CORNER_AW'(cmd.axis);
	end

	// corner memory
	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			corner_mem[waddr] <= bcot_pkg::sat32({{33{csum[33]}}, csum});
		if (cmd.rd_en)
			rdata_s1 <= cvalid_q[raddr] ? corner_mem[raddr] : 32'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvalid_q <= '0;
			rdv_s1 <= 1'b0;
			rdoth_s1 <= 1'b0;
			rdfirst_s1 <= 1'b0;
		end else begin
			if (cmd.wr_en)
				cvalid_q[waddr] <= 1'b1;
			rdv_s1 <= cmd.rd_en;
			rdoth_s1 <= cmd.rd_other;
			rdfirst_s1 <= cmd.rd_first;
		end
	end

	// running min and max per box
	always_ff @(posedge clk) begin
		if (rdv_s1) begin
			if (!rdoth_s1) begin
				if (rdfirst_s1 || rdata_s1 < amin_q) amin_q <= rdata_s1;
				if (rdfirst_s1 || rdata_s1 > amax_q) amax_q <= rdata_s1;
			end else begin
				if (rdfirst_s1 || rdata_s1 < bmin_q) bmin_q <= rdata_s1;
				if (rdfirst_s1 || rdata_s1 > bmax_q) bmax_q <= rdata_s1;
			end
		end
	end

	// interval check per axis
	logic signed [31:0] lo_max, hi_min;
	logic axis_ok;
	always_comb begin
		lo_max = (amin_q > bmin_q) ? amin_q : bmin_q;
		hi_min = (amax_q < bmax_q) ? amax_q : bmax_q;
		axis_ok = (ext_q[box_q][cmd.axis] != 32'sd0) && (lo_max <= hi_min);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovl_q <= 1'b0;
		else if (cmd.cmp_en)
			ovl_q <= axis_ok && (cmd.cmp_first || ovl_q);
	end

	assign ovl = ovl_q;

endmodule

/* hdl/bcot_ctrl.sv */
// controller: sequences update and test, owns the result register
module bcot_ctrl (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic [1:0] op,
	output logic s_tready,
	output logic load,
	output logic m_tvalid,
	output logic m_overlap,
	input logic m_tready,
	input logic ovl,
	output bcot_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UMUL = 3'd1;
	localparam logic [2:0] ST_UDRN = 3'd2;
	localparam logic [2:0] ST_UWR = 3'd3;
	localparam logic [2:0] ST_TRD = 3'd4;
	localparam logic [2:0] ST_TDRN = 3'd5;
	localparam logic [2:0] ST_TCMP = 3'd6;
	localparam logic [2:0] ST_TOUT = 3'd7;

	logic [2:0] state_q;
	logic [1:0] axis_q;
	logic [3:0] step_q;
	logic out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign load = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	// command decode
	always_comb begin
		cmd = '0;
		cmd.axis = axis_q;
		cmd.dst = bcot_pkg::DST_NONE;
		unique case (state_q)
			ST_UMUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_edge = (step_q >= 4'd3);
				cmd.col = (step_q >= 4'd3) ? 2'(step_q - 4'd3) : step_q[1:0];
				if (step_q == 4'd0)
					cmd.dst = bcot_pkg::DST_FIRST;
				else if (step_q == 4'd1)
					cmd.dst = bcot_pkg::DST_MID;
				else if (step_q == 4'd2)
					cmd.dst = bcot_pkg::DST_LAST;
				else
					cmd.dst = bcot_pkg::DST_EDGE;
			end
			ST_UWR: begin
				cmd.wr_en = 1'b1;
				cmd.corner = step_q[2:0];
			end
			ST_TRD: begin
				cmd.rd_en = 1'b1;
				cmd.corner = step_q[2:0];
				cmd.rd_other = step_q[3];
				cmd.rd_first = (step_q[2:0] == 3'd0);
			end
			ST_TCMP: begin
				cmd.cmp_en = 1'b1;
				cmd.cmp_first = (axis_q == 2'd0);
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= '0;
			step_q <= '0;
			m_tvalid <= 1'b0;
			m_overlap <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && !(state_q == ST_TOUT && out_free))
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					axis_q <= '0;
					step_q <= '0;
					if (load && op == bcot_pkg::OP_UPDATE)
						state_q <= ST_UMUL;
					else if (load && op == bcot_pkg::OP_TEST)
						state_q <= ST_TRD;
				end
				ST_UMUL: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd5)
						state_q <= ST_UDRN;
				end
				ST_UDRN: begin
					step_q <= '0;
					state_q <= ST_UWR;
				end
				ST_UWR: begin
					if (step_q == 4'd7) begin
						step_q <= '0;
						axis_q <= axis_q + 2'd1;
						state_q <= (axis_q == 2'd2) ? ST_IDLE : ST_UMUL;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_TRD: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15)
						state_q <= ST_TDRN;
				end
				ST_TDRN: state_q <= ST_TCMP;
				ST_TCMP: begin
					step_q <= '0;
					axis_q <= axis_q + 2'd1;
					state_q <= (axis_q == 2'd2) ? ST_TOUT : ST_TRD;
				end
				default: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_overlap <= ovl;
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// only one datapath action per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.mul_en, cmd.wr_en, cmd.rd_en, cmd.cmp_en}))
		else $error("conflicting datapath commands");

	// an accepted test starts reading corners of axis zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(load && op == bcot_pkg::OP_TEST) |=> (state_q == ST_TRD && axis_q == 2'd0
		&& step_q == 4'd0))
		else $error("test did not start");

	// a result is posted only after the last axis compare
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_TOUT))
		else $error("result posted outside output step");

	// the multiply step count stays within six products
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UMUL) |-> (step_q <= 4'd5))
		else $error("multiply step out of range");

endmodule

/* hdl/box_corner_overlap_test_unit.sv */
// top level of the box corner overlap test unit
//
// channel   dir   tdata                         tuser
// s_*       in    v0..v5, 32 bits each          operation[1:0], box[2], row[4:3]
// m_*       out   overlap (bit 0, padded to 8)  -
//
// set origin/extents and load matrix row are written when the item is accepted.
// update: per axis six products on the one multiplier, a drain step and eight
// corner writes into the single-port corner memory.
// test: per axis sixteen corner reads, one drain, one compare, then an output
// step to post the result; it waits there while the result is held.
// reset is asynchronous and clears all box state; corners read as zero until
// written.
module box_corner_overlap_test_unit #(
	parameter int FRAC_BITS = bcot_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [191:0] s_tdata, // v0, v1, v2, v3, v4, v5
	input logic [4:0] s_tuser, // operation, box, row
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata // overlap, zero pad
);

	bcot_pkg::cmd_t cmd;
	logic load;
	logic ovl;
	logic overlap;

	bcot_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.op(s_tuser[1:0]),
		.s_tready(s_tready),
		.load(load),
		.m_tvalid(m_tvalid),
		.m_overlap(overlap),
		.m_tready(m_tready),
		.ovl(ovl),
		.cmd(cmd)
	);

	bcot_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.op(s_tuser[1:0]),
		.box(s_tuser[2]),
		.row(s_tuser[4:3]),
		.vals(s_tdata),
		.cmd(cmd),
		.ovl(ovl)
	);

	assign m_tdata = {7'd0, overlap};

endmodule

/* bench/tb_top.sv */
// testbench for the box corner overlap test unit with its own overlap predictor
class overlap_board;
	int signed origin[6];
	int signed extent[6];
	int signed mat[24];
	int signed corner[48];
	bit want_q[$];
	int errors;

	function new();
		foreach (origin[i]) origin[i] = 0;
		foreach (extent[i]) extent[i] = 0;
		foreach (mat[i]) mat[i] = 0;
		foreach (corner[i]) corner[i] = 0;
		errors = 0;
	endfunction

	// floor divide by 2^16
	function automatic longint fshift(longint v);
		return v >>> 16;
	endfunction

	function automatic int signed clamp(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic void rebuild(int b);
		int signed off[3];
		int signed ed[3][3];
		longint s;
		logic [2:0] sel;
		for (int i = 0; i < 3; i++) begin
			longint p0, p1, p2, h;
			p0 = longint'(mat[b*12+i*4]) * origin[b*3];
			p1 = longint'(mat[b*12+i*4+1]) * origin[b*3+1];
			p2 = longint'(mat[b*12+i*4+2]) * origin[b*3+2];
			// sum of three products fits in 66 bits; floor each then the remainder
			h = fshift(p0) + fshift(p1) + fshift(p2);
			h = h + fshift((p0 & 64'hffff) + (p1 & 64'hffff) + (p2 & 64'hffff));
			off[i] = clamp(h + mat[b*12+i*4+3]);
			for (int j = 0; j < 3; j++)
				ed[j][i] = clamp(fshift(longint'(mat[b*12+i*4+j]) * extent[b*3+j]));
		end
		for (int c = 0; c < 8; c++) begin
			case (c)
				0: sel = 3'b000; 1: sel = 3'b001; 2: sel = 3'b010; 3: sel = 3'b100;
				4: sel = 3'b011; 5: sel = 3'b101; 6: sel = 3'b110; default: sel = 3'b111;
			endcase
			for (int i = 0; i < 3; i++) begin
				s = off[i];
				for (int j = 0; j < 3; j++)
					if (sel[j]) s += ed[j][i];
				corner[b*24+c*3+i] = clamp(s);
			end
		end
	endfunction

	function automatic bit overlaps(int b);
		int o;
		int signed alo, ahi, blo, bhi, v;
		o = 1 - b;
		for (int a = 0; a < 3; a++) begin
			if (extent[b*3+a] == 0) return 0;
			alo = corner[b*24+a]; ahi = alo;
			blo = corner[o*24+a]; bhi = blo;
			for (int c = 1; c < 8; c++) begin
				v = corner[b*24+c*3+a];
				if (v < alo) alo = v;
				if (v > ahi) ahi = v;
				v = corner[o*24+c*3+a];
				if (v < blo) blo = v;
				if (v > bhi) bhi = v;
			end
			if ((alo > blo ? alo : blo) > (ahi < bhi ? ahi : bhi)) return 0;
		end
		return 1;
	endfunction

	// note an accepted input item
	function void note_item(logic [4:0] user, logic [191:0] data);
		logic [1:0] op;
		int b, r;
		op = user[1:0];
		b = int'(user[2]);
		r = int'(user[4:3]);
		case (op)
			bcot_pkg::OP_SET_BOX: for (int k = 0; k < 3; k++) begin
				origin[b*3+k] = data[32*k +: 32];
				extent[b*3+k] = data[32*(k+3) +: 32];
			end
			bcot_pkg::OP_LOAD_ROW: if (r < 3)
				for (int k = 0; k < 4; k++) mat[b*12+r*4+k] = data[32*k +: 32];
			bcot_pkg::OP_UPDATE: rebuild(b);
			default: want_q.push_back(overlaps(b));
		endcase
	endfunction

	// compare one result with the oldest expected overlap
	function void check_result(logic [7:0] d);
		bit w;
		if (want_q.size() == 0) begin
			$display("%0t unexpected result: expected none, actual %h", $time, d);
			errors++;
			return;
		end
		w = want_q.pop_front();
		if (d !== {7'd0, w}) begin
			$display("%0t overlap mismatch: expected %h, actual %h", $time, {7'd0, w}, d);
			errors++;
		end
	endfunction
endclass

module tb_top;
	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [191:0] s_tdata = '0;
	logic [4:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [7:0] m_tdata;

	overlap_board board = new();
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_off = 0;
	int quiet = 0;

	box_corner_overlap_test_unit DUT (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// receiver side with random stalls and a long hold-off
	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check_result(m_tdata);
		m_tready <= !hold_off && ($urandom_range(99) >= recv_stall);
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 5000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task send(logic [1:0] op, logic b, logic [1:0] r, logic [191:0] d);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= {r, b, op};
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		board.note_item({r, b, op}, d);
	endtask

	function automatic logic [31:0] rnd_val();
		case ($urandom_range(5))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'd0;
			3: return $urandom;
			default: return $signed($urandom_range(16'hffff, 0)) * 8 - 32'sh40000;
		endcase
	endfunction

	function automatic logic [191:0] rnd_data(bit tame);
		logic [191:0] d;
		for (int k = 0; k < 6; k++)
			d[32*k +: 32] = tame ? ($signed($urandom_range(8'hff)) <<< 12) - 32'sh80000
				: rnd_val();
		return d;
	endfunction

	// one well-formed sequence: set box, load rows, update, test
	task box_sequence(bit tame);
		logic b;
		logic [191:0] d;
		b = 1'($urandom_range(1));
		d = rnd_data(tame);
		if ($urandom_range(9) == 0) d[32*($urandom_range(2)+3) +: 32] = 0;
		send(bcot_pkg::OP_SET_BOX, b, 2'($urandom_range(3)), d);
		for (int r = 0; r < 3; r++) begin
			d = rnd_data(tame);
			if (tame) d[32*r +: 32] = $urandom_range(1) ? 32'h10000 : 32'hffff0000;
			send(bcot_pkg::OP_LOAD_ROW, b, 2'(r), d);
		end
		send(bcot_pkg::OP_UPDATE, b, 2'($urandom_range(3)), {$urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom});
		send(bcot_pkg::OP_TEST, 1'($urandom_range(1)), 2'($urandom_range(3)),
			rnd_data(1'b0));
	endtask

	task drain();
		s_tvalid <= 0;
		while (board.want_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		int idle_set[4];
		int stall_set[4];
		idle_set = '{0, 60, 0, 12};
		stall_set = '{0, 0, 60, 12};
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: tests on reset state, extremes, ignored row, negative extent
		send(bcot_pkg::OP_TEST, 1'b0, 2'd0, '0);
		send(bcot_pkg::OP_SET_BOX, 1'b0, 2'd0, {32'h00010000, 32'hffff0000, 32'h00020000,
			32'h7fffffff, 32'h80000000, 32'd0});
		send(bcot_pkg::OP_TEST, 1'b0, 2'd0, '0);
		send(bcot_pkg::OP_LOAD_ROW, 1'b0, 2'd3, {6{32'hffffffff}});
		for (int r = 0; r < 3; r++)
			send(bcot_pkg::OP_LOAD_ROW, 1'b0, 2'(r), {64'd0, 32'h7fffffff, 32'h80000000,
				32'h80000000, 32'h7fffffff});
		send(bcot_pkg::OP_UPDATE, 1'b0, 2'd0, '0);
		send(bcot_pkg::OP_TEST, 1'b0, 2'd0, '0);
		send(bcot_pkg::OP_TEST, 1'b1, 2'd0, '0);
		send(bcot_pkg::OP_SET_BOX, 1'b1, 2'd2, {32'hfffe0000, 32'hfffe0000, 32'hfffe0000,
			32'h10000, 32'h10000, 32'h10000});
		for (int r = 0; r < 3; r++)
			send(bcot_pkg::OP_LOAD_ROW, 1'b1, 2'(r),
				{64'd0, 32'h8000, 96'd0} | (192'h10000 << (32*r)));
		send(bcot_pkg::OP_UPDATE, 1'b1, 2'd0, '0);
		send(bcot_pkg::OP_TEST, 1'b1, 2'd0, '0);
		send(bcot_pkg::OP_TEST, 1'b0, 2'd0, '0);
		send(bcot_pkg::OP_UPDATE, 1'b0, 2'd0, '1);
		send(bcot_pkg::OP_TEST, 1'b1, 2'd3, '1);
		drain();

		// random phases with varied idling
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = idle_set[ph];
			recv_stall = stall_set[ph];
			for (int n = 0; n < 85; n++) begin
				if ($urandom_range(9) < 8) box_sequence($urandom_range(3) != 0);
				else send(2'($urandom_range(3)), 1'($urandom_range(1)),
					2'($urandom_range(3)), rnd_data(1'b0));
			end
			drain();
		end

		// long receiver hold-off while items keep coming
		send_idle = 0;
		recv_stall = 0;
		hold_off = 1;
		fork
			begin
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
			for (int n = 0; n < 10; n++)
				send(bcot_pkg::OP_TEST, 1'($urandom_range(1)), 2'd0, '0);
		join
		drain();

		if (board.errors == 0 && board.want_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
